FILE: rtl/core/prmt_pkg.sv
// Shared types and constants for the pending request match table.
package prmt_pkg;

    localparam int ADDR_W   = 32;
    localparam int REQ_W    = 32;
    localparam int STATUS_W = 3;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 104;

    localparam logic [STATUS_W-1:0] ST_ENQUEUED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HELD      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MATCHED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED = 3'd4;

    localparam logic OP_REQUEST    = 1'b0;
    localparam logic OP_COMPLETION = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
    } t_entry;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REQ_W-1:0]    woken;
        logic [REQ_W-1:0]    released;
        logic                fwd_valid;
        logic [ADDR_W-1:0]   fwd_addr;
    } t_result;

endpackage

FILE: rtl/core/prmt_mem.sv
// Entry table memory: one write port, one registered read port.
module prmt_mem #(
    parameter int TABLE_DEPTH = 64,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  prmt_pkg::t_entry  i_wdata,
    input  logic              i_re,
    input  logic [IDX_W-1:0]  i_raddr,
    output prmt_pkg::t_entry  o_rdata
);
    import prmt_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/prmt_ctrl.sv
// Sequencer: pointers, hold register, request insert and completion search.
module prmt_ctrl #(
    parameter int TABLE_DEPTH = 64,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_op,
    input  logic [prmt_pkg::ADDR_W-1:0]   i_addr,
    input  logic [prmt_pkg::REQ_W-1:0]    i_req,
    output logic                          o_busy,
    output logic                          o_done,
    output prmt_pkg::t_result             o_result,
    output logic                          o_mem_we,
    output logic [IDX_W-1:0]              o_mem_waddr,
    output prmt_pkg::t_entry              o_mem_wdata,
    output logic                          o_mem_re,
    output logic [IDX_W-1:0]              o_mem_raddr,
    input  prmt_pkg::t_entry              i_mem_rdata
);
    import prmt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_MOVE = 2'd2;
    localparam logic [1:0] S_INS  = 2'd3;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] n);
        if (n == IDX_W'(TABLE_DEPTH - 1)) begin
            return '0;
        end
        return n + 1'b1;
    endfunction

    logic [1:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic              r_hold_vld, n_hold_vld;
    t_entry            r_hold, n_hold;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [ADDR_W-1:0] r_key, n_key;
    logic              r_first, n_first;
    t_entry            r_tail_ent, n_tail_ent;
    logic [IDX_W-1:0]  r_match_idx, n_match_idx;
    logic [REQ_W-1:0]  r_woken, n_woken;

    logic [IDX_W-1:0]  w_nxt_cur;
    logic [IDX_W-1:0]  w_new_tail;

    assign w_nxt_cur  = f_next(r_cur);
    assign w_new_tail = f_next(r_tail);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_hold_vld  = r_hold_vld;
        n_hold      = r_hold;
        n_cur       = r_cur;
        n_key       = r_key;
        n_first     = r_first;
        n_tail_ent  = r_tail_ent;
        n_match_idx = r_match_idx;
        n_woken     = r_woken;
        o_done      = 1'b0;
        o_result    = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_head;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_cur;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_op == OP_REQUEST) begin
                        o_done = 1'b1;
                        if (i_req == '0) begin
                            o_result.status = ST_REJECTED;
                        end else if (f_next(r_head) == r_tail) begin
                            if (r_hold_vld) begin
                                o_result.status = ST_REJECTED;
                            end else begin
                                n_hold_vld      = 1'b1;
                                n_hold.addr     = i_addr;
                                n_hold.req      = i_req;
                                o_result.status = ST_HELD;
                            end
                        end else begin
                            o_mem_we             = 1'b1;
                            o_mem_waddr          = r_head;
                            o_mem_wdata.addr     = i_addr;
                            o_mem_wdata.req      = i_req;
                            n_head               = f_next(r_head);
                            o_result.status      = ST_ENQUEUED;
                            o_result.fwd_valid   = 1'b1;
                            o_result.fwd_addr    = i_addr;
                        end
                    end else if (r_tail == r_head) begin
                        o_done          = 1'b1;
                        o_result.status = ST_UNMATCHED;
                    end else begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = r_tail;
                        n_cur       = r_tail;
                        n_key       = i_addr;
                        n_first     = 1'b1;
                        n_state     = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                n_first = 1'b0;
                if (r_first) begin
                    n_tail_ent = i_mem_rdata;
                end
                if (i_mem_rdata.addr == r_key) begin
                    n_match_idx = r_cur;
                    n_woken     = i_mem_rdata.req;
                    n_state     = S_MOVE;
                end else if (w_nxt_cur == r_head) begin
                    o_done          = 1'b1;
                    o_result.status = ST_UNMATCHED;
                    n_state         = S_IDLE;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = w_nxt_cur;
                    n_cur       = w_nxt_cur;
                end
            end
            S_MOVE: begin
                if (r_match_idx != r_tail) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_match_idx;
                    o_mem_wdata = r_tail_ent;
                end
                n_tail = w_new_tail;
                if (r_hold_vld && (f_next(r_head) != w_new_tail)) begin
                    n_state = S_INS;
                end else begin
                    o_done          = 1'b1;
                    o_result.status = ST_MATCHED;
                    o_result.woken  = r_woken;
                    n_state         = S_IDLE;
                end
            end
            S_INS: begin
                o_mem_we           = 1'b1;
                o_mem_waddr        = r_head;
                o_mem_wdata        = r_hold;
                n_head             = f_next(r_head);
                n_hold_vld         = 1'b0;
                o_done             = 1'b1;
                o_result.status    = ST_MATCHED;
                o_result.woken     = r_woken;
                o_result.released  = r_hold.req;
                o_result.fwd_valid = 1'b1;
                o_result.fwd_addr  = r_hold.addr;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_hold_vld <= 1'b0;
            r_first    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_hold_vld <= n_hold_vld;
            r_first    <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold      <= n_hold;
        r_cur       <= n_cur;
        r_key       <= n_key;
        r_tail_ent  <= n_tail_ent;
        r_match_idx <= n_match_idx;
        r_woken     <= n_woken;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/core/pending_request_match_table_top.sv
// Top level of the pending request match table with stream ports and result register.
//
// Tracks up to TABLE_DEPTH-1 outstanding requests in a circular table held in a
// simple dual-port synchronous memory, plus one hold register for a request that finds
// the table full. A request (or a completion that finds the table empty) is
// handled in the cycle it is accepted. A completion scans the table from the
// oldest entry, one entry per cycle through the memory read port, then retires the
// match and, when a request is held, inserts the held request. One item
// is in flight at a time; the result sits in an output register and the next
// item is taken as soon as that register is free or being drained.
module pending_request_match_table_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [prmt_pkg::S_DATA_W-1:0]  i_s_tdata,  // request_address, requester_id
    input  logic                           i_s_tuser,  // operation
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [prmt_pkg::M_DATA_W-1:0]  o_m_tdata,  // woken_requester, released_requester,
                                                       // forward_valid, forward_address, zero pad
    output logic [prmt_pkg::STATUS_W-1:0]  o_m_tuser   // status
);
    import prmt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic             w_accept;
    logic             w_busy;
    logic             w_done;
    t_result          w_res;
    logic             w_mem_we;
    logic [IDX_W-1:0] w_mem_waddr;
    t_entry           w_mem_wdata;
    logic             w_mem_re;
    logic [IDX_W-1:0] w_mem_raddr;
    t_entry           w_mem_rdata;

    logic             r_out_vld;
    t_result          r_out;

    assign o_s_tready = !w_busy && (!r_out_vld || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    prmt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_op        (i_s_tuser),
        .i_addr      (i_s_tdata[ADDR_W-1:0]),
        .i_req       (i_s_tdata[ADDR_W+REQ_W-1:ADDR_W]),
        .o_busy      (w_busy),
        .o_done      (w_done),
        .o_result    (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    prmt_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_done) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {
        (M_DATA_W - 2*REQ_W - 1 - ADDR_W)'(0),
        r_out.fwd_addr,
        r_out.fwd_valid,
        r_out.released,
        r_out.woken
    };

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |-> !w_done)
        else $error("result register overwritten while stalled");

    a_request_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_s_tuser == OP_REQUEST)) |-> (w_done && !w_busy))
        else $error("request did not complete in its accept cycle");

    a_busy_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_busy) |-> $past(w_accept))
        else $error("search started without an accepted beat");

endmodule

FILE: dv/tb_top.sv
// Self-checking stream testbench for pending_request_match_table_top with a built-in predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prmt_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 1500000;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata  = '0;  // request_address, requester_id
    logic                  i_s_tuser  = 1'b0;  // operation
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;  // woken, released, forward_valid, forward_address, pad
    logic [STATUS_W-1:0]   o_m_tuser;  // status

    pending_request_match_table_top #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predicted table state
    logic [ADDR_W-1:0] pend_addr [DEPTH];
    logic [REQ_W-1:0]  pend_req  [DEPTH];
    int                head_ptr;
    int                tail_ptr;
    logic              hold_busy;
    logic [ADDR_W-1:0] hold_addr;
    logic [REQ_W-1:0]  hold_req;

    t_result expected_results [$];
    int      error_count     = 0;
    int      cycle_count     = 0;
    int      stall_left      = 0;
    int      hold_off_cycles = 0;
    bit      src_quiet       = 1'b0;
    bit      sink_quiet      = 1'b0;

    function automatic int next_slot(input int n);
        return (n + 1) % DEPTH;
    endfunction

    function automatic int occupancy();
        return (head_ptr - tail_ptr + DEPTH) % DEPTH;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_result track_request(input logic op, input logic [ADDR_W-1:0] addr,
                                              input logic [REQ_W-1:0] who);
        t_result r;
        int      idx;
        bit      found;
        r = '0;
        if (op == OP_REQUEST) begin
            if (who == '0) begin
                r.status = ST_REJECTED;
            end else if (next_slot(head_ptr) == tail_ptr) begin
                if (hold_busy) begin
                    r.status = ST_REJECTED;
                end else begin
                    hold_busy = 1'b1;
                    hold_addr = addr;
                    hold_req  = who;
                    r.status  = ST_HELD;
                end
            end else begin
                pend_addr[head_ptr] = addr;
                pend_req[head_ptr]  = who;
                head_ptr    = next_slot(head_ptr);
                r.fwd_valid = 1'b1;
                r.fwd_addr  = addr;
                r.status    = ST_ENQUEUED;
            end
        end else begin
            idx   = tail_ptr;
            found = 1'b0;
            while (idx != head_ptr && !found) begin
                if (pend_addr[idx] == addr) found = 1'b1;
                else idx = next_slot(idx);
            end
            if (!found) begin
                r.status = ST_UNMATCHED;
            end else begin
                r.woken  = pend_req[idx];
                r.status = ST_MATCHED;
                pend_addr[idx]      = pend_addr[tail_ptr];
                pend_req[idx]       = pend_req[tail_ptr];
                pend_addr[tail_ptr] = '0;
                pend_req[tail_ptr]  = '0;
                tail_ptr = next_slot(tail_ptr);
                if (hold_busy && next_slot(head_ptr) != tail_ptr) begin
                    pend_addr[head_ptr] = hold_addr;
                    pend_req[head_ptr]  = hold_req;
                    head_ptr    = next_slot(head_ptr);
                    r.fwd_valid = 1'b1;
                    r.fwd_addr  = hold_addr;
                    r.released  = hold_req;
                    hold_busy   = 1'b0;
                    hold_addr   = '0;
                    hold_req    = '0;
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // called at a rising edge; returns at the edge the beat is taken
    task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [REQ_W-1:0] who);
        int gap;
        gap = src_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {who, addr};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        expected_results.push_back(track_request(op, addr, who));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            i_m_tready      <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (sink_quiet) begin
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            stall_left = pick_gap();
            i_m_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left = stall_left - 1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result exp_r;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat expected none actual status %0d tdata %h",
                         $time, o_m_tuser, o_m_tdata);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("status", 32'(exp_r.status), 32'(o_m_tuser));
                check_field("woken_requester", exp_r.woken, o_m_tdata[31:0]);
                check_field("released_requester", exp_r.released, o_m_tdata[63:32]);
                check_field("forward_valid", 32'(exp_r.fwd_valid), 32'(o_m_tdata[64]));
                check_field("forward_address", exp_r.fwd_addr, o_m_tdata[96:65]);
                check_field("pad", 32'd0, 32'(o_m_tdata[103:97]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("pending_request_match_table_top verification failed");
            $finish;
        end
    end

    task automatic test_edges();
        send_item(OP_COMPLETION, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_COMPLETION, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_REQUEST,    32'h1234_5678, 32'h0000_0000);
        send_item(OP_REQUEST,    32'h0000_0000, 32'h0000_0001);
        send_item(OP_REQUEST,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_REQUEST,    32'h0000_0000, 32'h0000_0002);
        send_item(OP_REQUEST,    32'h5555_AAAA, 32'hAAAA_5555);
        send_item(OP_COMPLETION, 32'h1234_5678, 32'h0000_0000);
        send_item(OP_COMPLETION, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_COMPLETION, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_COMPLETION, 32'h0000_0000, 32'h8000_0001);
        send_item(OP_COMPLETION, 32'h5555_AAAA, 32'h0000_0000);
        send_item(OP_COMPLETION, 32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic test_full_table();
        int k;
        src_quiet = 1'b1;
        for (k = 0; k < DEPTH - 1; k++) begin
            send_item(OP_REQUEST, 32'hC000_0000 | 32'(k), 32'(k + 1));
        end
        send_item(OP_REQUEST, 32'hA5A5_0001, 32'h0000_0077);
        send_item(OP_REQUEST, 32'hA5A5_0002, 32'h0000_0078);
        send_item(OP_REQUEST, 32'hA5A5_0003, 32'h0000_0000);
        send_item(OP_COMPLETION, 32'hDEAD_BEEF, 32'h0000_0000);
        send_item(OP_COMPLETION, 32'hC000_001E, 32'h0000_0000);
        send_item(OP_REQUEST, 32'hA5A5_0004, 32'hFFFF_FFFE);
        src_quiet = 1'b0;
        while (occupancy() > 0) begin
            k = (tail_ptr + $urandom_range(0, occupancy() - 1)) % DEPTH;
            send_item(OP_COMPLETION, pend_addr[k], $urandom);
        end
    endtask

    task automatic test_output_stall();
        int k;
        src_quiet = 1'b1;
        hold_off_cycles <= 400;
        for (k = 0; k < 30; k++) begin
            if (k % 3 == 2 && occupancy() > 0) begin
                send_item(OP_COMPLETION, pend_addr[tail_ptr], 32'h0000_0000);
            end else begin
                send_item(OP_REQUEST, $urandom, 32'(k + 100));
            end
        end
        src_quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        int                sent;
        int                phase_len;
        int                req_pct;
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [REQ_W-1:0]  who;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(40, 160);
            case ($urandom_range(0, 3))
                0: req_pct = 85;
                1: req_pct = 15;
                default: req_pct = 50;
            endcase
            src_quiet  = ($urandom_range(0, 5) == 0);
            sink_quiet = ($urandom_range(0, 5) == 0);
            repeat (phase_len) begin
                if ($urandom_range(0, 99) < req_pct) begin
                    op   = OP_REQUEST;
                    addr = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
                    who  = ($urandom_range(0, 29) == 0) ? '0 : $urandom;
                end else begin
                    op  = OP_COMPLETION;
                    who = $urandom;
                    if (occupancy() > 0 && $urandom_range(0, 9) < 8) begin
                        addr = pend_addr[(tail_ptr + $urandom_range(0, occupancy() - 1)) % DEPTH];
                    end else begin
                        addr = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
                    end
                end
                send_item(op, addr, who);
                sent++;
            end
        end
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
    endtask

    initial begin
        for (int k = 0; k < DEPTH; k++) begin
            pend_addr[k] = '0;
            pend_req[k]  = '0;
        end
        head_ptr  = 0;
        tail_ptr  = 0;
        hold_busy = 1'b0;
        hold_addr = '0;
        hold_req  = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_edges();
        test_full_table();
        test_output_stall();
        test_random_traffic();

        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("pending_request_match_table_top verification clean");
        end else begin
            $display("pending_request_match_table_top verification failed");
        end
        $finish;
    end

endmodule

FILE: pending_request_match_table_top.f
rtl/core/prmt_pkg.sv
rtl/core/prmt_mem.sv
rtl/core/prmt_ctrl.sv
rtl/core/pending_request_match_table_top.sv
dv/tb_top.sv
